>>> sv/vtc_pkg.sv
`timescale 1ns / 1ps
package vtc_pkg;

	localparam int MUL_LAT   = 3;
	localparam int ADD_LAT   = 4;
	localparam int DIV_ITER  = 26;
	localparam int DIV_LAT   = DIV_ITER + 2;
	localparam int LANE_LAT  = MUL_LAT + 3 * ADD_LAT;
	localparam int TOTAL_LAT = LANE_LAT + DIV_LAT + 1;

	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = 4;

	localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

	localparam logic [NUM_REGS-1:0][63:0] MAT_RESET = {
		64'h3F80_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_3F80_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h3F80_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_3F80_0000
	};

	// unpacked binary32 operand; ee is the effective exponent (1 for subnormals)
	typedef struct packed {
		logic        sign;
		logic [7:0]  ee;
		logic [23:0] man;
		logic        nan;
		logic        inf;
		logic        zero;
	} fp_unp_t;

	// special-case flags carried down a unit's pipeline
	typedef struct packed {
		logic nan;
		logic inf;
		logic zero;
		logic sign;
	} fp_flag_t;

	function automatic fp_unp_t fp_unpack(input logic [31:0] v);
		fp_unp_t u;
		u.sign = v[31];
		u.ee   = (v[30:23] == 8'd0) ? 8'd1 : v[30:23];
		u.man  = {|v[30:23], v[22:0]};
		u.nan  = (&v[30:23]) & (|v[22:0]);
		u.inf  = (&v[30:23]) & ~(|v[22:0]);
		u.zero = ~(|v[30:0]);
		return u;
	endfunction

	function automatic logic [5:0] lzc48(input logic [47:0] v);
		logic [5:0] n;
		n = 6'd48;
		for (int i = 0; i < 48; i++) begin
			if (v[i]) n = 6'(47 - i);
		end
		return n;
	endfunction

	// m: leading one at bit 26, fraction 25:3, guard bit 2, sticky 1:0
	function automatic logic [31:0] round_pack(input logic sign, input logic signed [10:0] ex,
		input logic [26:0] m);
		logic [26:0] sm;
		logic [10:0] sh;
		logic [7:0]  ef;
		logic        inc;
		logic [31:0] res;
		sm = m;
		ef = ex[7:0];
		sh = '0;
		if (ex >= 11'sd255) begin
			res = {sign, 8'hFF, 23'd0};
		end else begin
			if (ex <= 11'sd0) begin
				sh = 11'(11'sd1 - ex);
				ef = '0;
				if (sh > 11'd26) sm = {26'd0, |m};
				else sm = (m >> sh[4:0]) | {26'd0, |(m & ~({27{1'b1}} << sh[4:0]))};
			end
			inc = sm[2] & (sm[3] | sm[1] | sm[0]);
			res = {sign, ef, sm[25:3]} + {31'd0, inc};
		end
		return res;
	endfunction

	function automatic logic [31:0] canon(input logic [31:0] v);
		return ((&v[30:23]) && (|v[22:0])) ? CANON_NAN : v;
	endfunction

endpackage

>>> sv/vertex_transform_coord.sv
`timescale 1ns / 1ps
// Homogeneous 4x4 transform of binary32 vectors.
// Input: pulse start with opcode and in_x/in_y/in_z; a word is taken on each
// clock edge where start is high and busy is low. busy stays low, so one
// vector can enter every cycle.
// Output: done is high for one cycle with out_x/out_y/out_z, once per word
// taken. The receiver cannot stall; results are never held.
// Pipeline: 3 multiply stages, three chained 4-stage adders and a divider
// (input register, 26 quotient-bit stages, rounding register), plus the
// output register.
// Opcode 0 divides by w (all-zero result if w is zero); opcode 1 skips
// translation and divide. NaN results come out as 0x7FC00000.
// Matrix: eight 64-bit registers on cfg_valid/cfg_index/cfg_data, always
// ready; indexes above 7 are dropped. Write only while no word is in flight.
// Reset loads the identity matrix and empties the pipeline.
module vertex_transform_coord (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          opcode,
	input  logic [31:0]                   in_x,
	input  logic [31:0]                   in_y,
	input  logic [31:0]                   in_z,
	output logic                          done,
	output logic [31:0]                   out_x,
	output logic [31:0]                   out_y,
	output logic [31:0]                   out_z,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [vtc_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data
);
	import vtc_pkg::*;

	logic [NUM_REGS-1:0][63:0] mat_q;
	logic [31:0] lin [0:3];
	logic [31:0] aff [0:3];
	logic [31:0] quo [0:2];
	logic [95:0] lin_dl [0:DIV_LAT-1];
	logic [31:0] w_dl   [0:DIV_LAT-1];
	logic [LANE_LAT+DIV_LAT-1:0] vld_dl;
	logic [LANE_LAT+DIV_LAT-1:0] op_dl;
	logic accept;
	logic w_zero;
	logic op_m;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start & ~busy;

	// matrix registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q <= MAT_RESET;
		end else if (cfg_valid && cfg_ready && cfg_index < REG_IDX_W'(NUM_REGS)) begin
			mat_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	// one lane per matrix column; column 3 yields w
	for (genvar c = 0; c < 4; c++) begin : g_lane
		vtc_lane u_lane (
			.clk(clk), .x(in_x), .y(in_y), .z(in_z),
			.m0 (mat_q[0 + c/2][(c%2)*32 +: 32]),
			.m1 (mat_q[2 + c/2][(c%2)*32 +: 32]),
			.m2 (mat_q[4 + c/2][(c%2)*32 +: 32]),
			.m3 (mat_q[6 + c/2][(c%2)*32 +: 32]),
			.lin(lin[c]), .aff(aff[c])
		);
	end

	for (genvar c = 0; c < 3; c++) begin : g_div
		vtc_fdiv u_div (.clk(clk), .a(aff[c]), .b(aff[3]), .y(quo[c]));
	end

	// hold direction results and w level with the divider
	always_ff @(posedge clk) begin
		lin_dl[0] <= {lin[2], lin[1], lin[0]};
		w_dl[0]   <= aff[3];
		for (int i = 1; i < DIV_LAT; i++) begin
			lin_dl[i] <= lin_dl[i-1];
			w_dl[i]   <= w_dl[i-1];
		end
	end

	// advance valid and opcode through the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_dl <= '0;
		end else begin
			vld_dl <= {vld_dl[LANE_LAT+DIV_LAT-2:0], accept};
		end
	end

	always_ff @(posedge clk) begin
		op_dl <= {op_dl[LANE_LAT+DIV_LAT-2:0], opcode};
	end

	// merge lanes into the result word
	assign op_m   = op_dl[LANE_LAT+DIV_LAT-1];
	assign w_zero = (w_dl[DIV_LAT-1][30:0] == 31'd0);

	always_ff @(posedge clk) begin
		if (op_m) begin
			out_x <= canon(lin_dl[DIV_LAT-1][31:0]);
			out_y <= canon(lin_dl[DIV_LAT-1][63:32]);
			out_z <= canon(lin_dl[DIV_LAT-1][95:64]);
		end else if (w_zero) begin
			out_x <= '0;
			out_y <= '0;
			out_z <= '0;
		end else begin
			out_x <= canon(quo[0]);
			out_y <= canon(quo[1]);
			out_z <= canon(quo[2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_dl[LANE_LAT+DIV_LAT-1];
		end
	end

	// every result traces back to a word taken a fixed latency earlier
	a_done_lat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, TOTAL_LAT))
		else $error("result without matching input word");

	// dropped register writes leave the matrix untouched
	a_cfg_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index >= REG_IDX_W'(NUM_REGS)) |=> $stable(mat_q))
		else $error("out-of-range write changed the matrix");

	// only the canonical NaN leaves the block
	a_nan_canon: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (&out_x[30:23]) && (|out_x[22:0])) |-> (out_x == CANON_NAN))
		else $error("non-canonical NaN on out_x");

endmodule

>>> sv/vtc_fmul.sv
`timescale 1ns / 1ps
module vtc_fmul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);
	import vtc_pkg::*;

	fp_unp_t ua, ub;
	fp_flag_t flg_c, flg_s1, flg_s2;
	logic [47:0] prod_s1, norm_s2;
	logic signed [10:0] exp_s1, exp_s2;
	logic [5:0] lz;

	assign ua = fp_unpack(a);
	assign ub = fp_unpack(b);

	always_comb begin
		flg_c.nan  = ua.nan | ub.nan | (ua.inf & ub.zero) | (ub.inf & ua.zero);
		flg_c.inf  = ua.inf | ub.inf;
		flg_c.zero = ua.zero | ub.zero;
		flg_c.sign = ua.sign ^ ub.sign;
	end

	// multiply mantissas
	always_ff @(posedge clk) begin
		prod_s1 <= ua.man * ub.man;
		exp_s1  <= $signed({3'b000, ua.ee}) + $signed({3'b000, ub.ee}) - 11'sd126;
		flg_s1  <= flg_c;
	end

	// normalize product to bit 47
	assign lz = lzc48(prod_s1);

	always_ff @(posedge clk) begin
		norm_s2 <= prod_s1 << lz;
		exp_s2  <= exp_s1 - $signed({5'b00000, lz});
		flg_s2  <= flg_s1;
	end

	// round and pack
	always_ff @(posedge clk) begin
		if (flg_s2.nan) y <= CANON_NAN;
		else if (flg_s2.inf) y <= {flg_s2.sign, 8'hFF, 23'd0};
		else if (flg_s2.zero) y <= {flg_s2.sign, 31'd0};
		else y <= round_pack(flg_s2.sign, exp_s2, {norm_s2[47:22], |norm_s2[21:0]});
	end

endmodule

>>> sv/vtc_fadd.sv
`timescale 1ns / 1ps
module vtc_fadd (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);
	import vtc_pkg::*;

	fp_unp_t ua, ub, big, sml;
	fp_flag_t flg_c, flg_s1, flg_s2, flg_s3;
	logic [7:0] d;
	logic [26:0] sml27, al;
	logic [26:0] big_s1, al_s1;
	logic sub_s1, sub_s2, sub_s3;
	logic signed [10:0] exp_s1, exp_s2, exp_s3;
	logic [27:0] sum_s2, norm_s3;
	logic zero_s3;
	logic [5:0] lz;

	assign ua = fp_unpack(a);
	assign ub = fp_unpack(b);

	// order by magnitude and align the smaller operand
	always_comb begin
		big   = (a[30:0] >= b[30:0]) ? ua : ub;
		sml   = (a[30:0] >= b[30:0]) ? ub : ua;
		d     = big.ee - sml.ee;
		sml27 = {sml.man, 3'b000};
		if (d > 8'd26) al = {26'd0, |sml.man};
		else al = (sml27 >> d[4:0]) | {26'd0, |(sml27 & ~({27{1'b1}} << d[4:0]))};
		flg_c.nan  = ua.nan | ub.nan | (ua.inf & ub.inf & (ua.sign ^ ub.sign));
		flg_c.inf  = ua.inf | ub.inf;
		flg_c.zero = 1'b0;
		flg_c.sign = (ua.inf | ub.inf) ? (ua.inf ? ua.sign : ub.sign) : big.sign;
	end

	always_ff @(posedge clk) begin
		big_s1 <= {big.man, 3'b000};
		al_s1  <= al;
		sub_s1 <= ua.sign ^ ub.sign;
		exp_s1 <= $signed({3'b000, big.ee});
		flg_s1 <= flg_c;
	end

	// add or subtract magnitudes
	always_ff @(posedge clk) begin
		sum_s2 <= sub_s1 ? ({1'b0, big_s1} - {1'b0, al_s1}) : ({1'b0, big_s1} + {1'b0, al_s1});
		sub_s2 <= sub_s1;
		exp_s2 <= exp_s1;
		flg_s2 <= flg_s1;
	end

	// normalize sum to bit 27
	assign lz = lzc48({sum_s2, 20'd0});

	always_ff @(posedge clk) begin
		norm_s3 <= sum_s2 << lz;
		exp_s3  <= exp_s2 + 11'sd1 - $signed({5'b00000, lz});
		zero_s3 <= (sum_s2 == 28'd0);
		sub_s3  <= sub_s2;
		flg_s3  <= flg_s2;
	end

	// round and pack; exact cancellation gives +0
	always_ff @(posedge clk) begin
		if (flg_s3.nan) y <= CANON_NAN;
		else if (flg_s3.inf) y <= {flg_s3.sign, 8'hFF, 23'd0};
		else if (zero_s3) y <= {flg_s3.sign & ~sub_s3, 31'd0};
		else y <= round_pack(flg_s3.sign, exp_s3, {norm_s3[27:2], |norm_s3[1:0]});
	end

endmodule

>>> sv/vtc_fdiv.sv
`timescale 1ns / 1ps
module vtc_fdiv (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);
	import vtc_pkg::*;

	fp_unp_t ua, ub;
	fp_flag_t flg_c;
	logic [5:0] lza, lzb;
	logic [23:0] mna, mnb;
	logic lt;
	logic signed [10:0] ex_c;

	logic [24:0]          rem_s [0:DIV_ITER];
	logic [23:0]          dvs_s [0:DIV_ITER];
	logic [DIV_ITER-1:0]  quo_s [0:DIV_ITER];
	logic signed [10:0]   exp_s [0:DIV_ITER];
	fp_flag_t             flg_s [0:DIV_ITER];

	assign ua = fp_unpack(a);
	assign ub = fp_unpack(b);

	// normalize subnormal mantissas and pre-scale the dividend
	always_comb begin
		lza  = lzc48({ua.man, 24'd0});
		lzb  = lzc48({ub.man, 24'd0});
		mna  = ua.man << lza;
		mnb  = ub.man << lzb;
		lt   = mna < mnb;
		ex_c = $signed({3'b000, ua.ee}) - $signed({5'b00000, lza})
			- $signed({3'b000, ub.ee}) + $signed({5'b00000, lzb})
			+ 11'sd127 - $signed({10'd0, lt});
		flg_c.nan  = ua.nan | ub.nan | (ua.zero & ub.zero) | (ua.inf & ub.inf);
		flg_c.inf  = ua.inf | ub.zero;
		flg_c.zero = ua.zero | ub.inf;
		flg_c.sign = ua.sign ^ ub.sign;
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= lt ? {mna, 1'b0} : {1'b0, mna};
		dvs_s[0] <= mnb;
		quo_s[0] <= '0;
		exp_s[0] <= ex_c;
		flg_s[0] <= flg_c;
	end

	// one quotient bit per stage
	for (genvar k = 0; k < DIV_ITER; k++) begin : g_step
		logic        ge;
		logic [24:0] rn;
		assign ge = rem_s[k] >= {1'b0, dvs_s[k]};
		assign rn = ge ? (rem_s[k] - {1'b0, dvs_s[k]}) : rem_s[k];
		always_ff @(posedge clk) begin
			rem_s[k+1] <= {rn[23:0], 1'b0};
			dvs_s[k+1] <= dvs_s[k];
			quo_s[k+1] <= {quo_s[k][DIV_ITER-2:0], ge};
			exp_s[k+1] <= exp_s[k];
			flg_s[k+1] <= flg_s[k];
		end
	end

	// round and pack
	always_ff @(posedge clk) begin
		if (flg_s[DIV_ITER].nan) y <= CANON_NAN;
		else if (flg_s[DIV_ITER].inf) y <= {flg_s[DIV_ITER].sign, 8'hFF, 23'd0};
		else if (flg_s[DIV_ITER].zero) y <= {flg_s[DIV_ITER].sign, 31'd0};
		else y <= round_pack(flg_s[DIV_ITER].sign, exp_s[DIV_ITER],
			{quo_s[DIV_ITER], |rem_s[DIV_ITER]});
	end

endmodule

>>> sv/vtc_lane.sv
`timescale 1ns / 1ps
module vtc_lane (
	input  logic        clk,
	input  logic [31:0] x,
	input  logic [31:0] y,
	input  logic [31:0] z,
	input  logic [31:0] m0,
	input  logic [31:0] m1,
	input  logic [31:0] m2,
	input  logic [31:0] m3,
	output logic [31:0] lin,
	output logic [31:0] aff
);
	import vtc_pkg::*;

	logic [31:0] p0, p1, p2, s1, s2;
	logic [31:0] p2_dl [0:ADD_LAT-1];
	logic [31:0] s2_dl [0:ADD_LAT-1];

	vtc_fmul u_mul0 (.clk(clk), .a(x), .b(m0), .y(p0));
	vtc_fmul u_mul1 (.clk(clk), .a(y), .b(m1), .y(p1));
	vtc_fmul u_mul2 (.clk(clk), .a(z), .b(m2), .y(p2));

	vtc_fadd u_add0 (.clk(clk), .a(p0), .b(p1), .y(s1));
	vtc_fadd u_add1 (.clk(clk), .a(s1), .b(p2_dl[ADD_LAT-1]), .y(s2));
	vtc_fadd u_add2 (.clk(clk), .a(s2), .b(m3), .y(aff));

	// hold the third product and the linear sum level with the adder chain
	always_ff @(posedge clk) begin
		p2_dl[0] <= p2;
		s2_dl[0] <= s2;
		for (int i = 1; i < ADD_LAT; i++) begin
			p2_dl[i] <= p2_dl[i-1];
			s2_dl[i] <= s2_dl[i-1];
		end
	end

	assign lin = s2_dl[ADD_LAT-1];

endmodule
